// File: hw/rtl/fuzzy_obstacle_avoid_drive_defines.svh
// ----------------------------------------------------------------------------
// fuzzy obstacle avoid drive assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef FUZZY_OBSTACLE_AVOID_DRIVE_DEFINES_SVH
`define FUZZY_OBSTACLE_AVOID_DRIVE_DEFINES_SVH

// property checked while out of reset
`define FOAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every edge, reset included
`define FOAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/foad_pkg.sv
// ----------------------------------------------------------------------------
// foad_pkg
// types, constants and the rule table of the fuzzy drive controller
// ----------------------------------------------------------------------------
`default_nettype none

package foad_pkg;

  localparam int BP_W              = 14;
  localparam int SPD_W             = 12;
  localparam int CFG_W             = 56;
  localparam int CFG_IDX_W         = 3;
  localparam int QUO_W             = 12;
  localparam int FRACTION_BITS_DEF = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRONT_BP = 3'd0,
    CFG_LEFT_BP  = 3'd1,
    CFG_RIGHT_BP = 3'd2,
    CFG_SLOW     = 3'd3,
    CFG_MEDIUM   = 3'd4,
    CFG_FAST     = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    RGN_NEAR,
    RGN_LOW_RAMP,
    RGN_MED,
    RGN_HIGH_RAMP,
    RGN_FAR
  } region_e;

  // speed class per rule {left wheel, right wheel}: 0 slow, 1 medium, 2 fast
  // rule index is front*9 + left*3 + right
  localparam logic [1:0] RULE_SPEED [27][2] = '{
    '{2'd0, 2'd2}, '{2'd1, 2'd0}, '{2'd2, 2'd0},
    '{2'd0, 2'd2}, '{2'd2, 2'd0}, '{2'd1, 2'd0},
    '{2'd0, 2'd1}, '{2'd0, 2'd2}, '{2'd2, 2'd0},
    '{2'd0, 2'd0}, '{2'd1, 2'd0}, '{2'd1, 2'd0},
    '{2'd0, 2'd1}, '{2'd0, 2'd0}, '{2'd1, 2'd2},
    '{2'd1, 2'd2}, '{2'd0, 2'd1}, '{2'd2, 2'd1},
    '{2'd1, 2'd1}, '{2'd2, 2'd1}, '{2'd2, 2'd0},
    '{2'd0, 2'd1}, '{2'd2, 2'd2}, '{2'd2, 2'd0},
    '{2'd1, 2'd2}, '{2'd1, 2'd2}, '{2'd2, 2'd2}
  };

endpackage

`default_nettype wire

// File: hw/rtl/fuzzy_obstacle_avoid_drive.sv
// ----------------------------------------------------------------------------
// fuzzy_obstacle_avoid_drive
// fuzzy obstacle avoidance controller, four sonar ranges in, two wheel speeds out
// ----------------------------------------------------------------------------
// The block takes one beat of four sonar ranges per cycle and returns one beat
// of left and right wheel speeds for every beat in, in order. The two bit-serial
// dividers are laid out as pipeline stages: one stage per membership fraction
// bit for the ramp memberships, and one stage per quotient bit for the final
// weighted average. The whole pipe advances together; it stalls only while a
// finished beat waits at the output and out_stall_i is high, so throughput is
// one beat per cycle. Breakpoint and speed registers are written through the
// cfg port and must only change while the pipe is empty.
`default_nettype none

module fuzzy_obstacle_avoid_drive #(
  parameter int FRACTION_BITS = foad_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration write port
  input  wire logic                                 cfg_we_i,
  input  wire logic [foad_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [foad_pkg::CFG_W-1:0]           cfg_data_i,
  // sonar beat
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [foad_pkg::BP_W-1:0]            front_left_range_i,
  input  wire logic [foad_pkg::BP_W-1:0]            front_right_range_i,
  input  wire logic [foad_pkg::BP_W-1:0]            left_range_i,
  input  wire logic [foad_pkg::BP_W-1:0]            right_range_i,
  // speed beat
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [foad_pkg::SPD_W-1:0]         left_speed_o,
  output logic signed [foad_pkg::SPD_W-1:0]         right_speed_o
);

  localparam int F    = FRACTION_BITS;
  localparam int BW   = foad_pkg::BP_W;
  localparam int SW   = foad_pkg::SPD_W;
  localparam int QW   = foad_pkg::QUO_W;
  localparam int MW   = F + 1;        // membership, 1.0 = 1 << F
  localparam int S9W  = F + 4;        // sum of 9 memberships
  localparam int SUMW = F + 5;        // sum of 27 memberships
  localparam int PW   = SUMW + SW + 1; // signed weight * center
  localparam int NW   = PW + 2;       // sum of three products

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [foad_pkg::CFG_W-1:0] bp_q  [3];
  logic signed [SW-1:0]       spd_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        bp_q[i]  <= '0;
        spd_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        foad_pkg::CFG_FRONT_BP: bp_q[0]  <= cfg_data_i;
        foad_pkg::CFG_LEFT_BP:  bp_q[1]  <= cfg_data_i;
        foad_pkg::CFG_RIGHT_BP: bp_q[2]  <= cfg_data_i;
        foad_pkg::CFG_SLOW:     spd_q[0] <= cfg_data_i[SW-1:0];
        foad_pkg::CFG_MEDIUM:   spd_q[1] <= cfg_data_i[SW-1:0];
        foad_pkg::CFG_FAST:     spd_q[2] <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: everything moves unless the output beat is held
  // --------------------------------------------------------------------------
  logic out_vld_q;
  logic adv;

  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;

  // --------------------------------------------------------------------------
  // stage a: sensor distances, front is the floor mean of the two front sonars
  // --------------------------------------------------------------------------
  logic [BW-1:0] x_q [3];
  logic          va_q;
  logic [BW:0]   front_sum;

  assign front_sum = {1'b0, front_left_range_i} + {1'b0, front_right_range_i};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0] <= front_sum[BW:1];
      x_q[1] <= left_range_i;
      x_q[2] <= right_range_i;
    end
  end

  // --------------------------------------------------------------------------
  // stage b: region and ramp operands; stages 1..F: one quotient bit each
  // lane 0 is the falling ramp, lane 1 the rising ramp
  // --------------------------------------------------------------------------
  logic [BW-1:0]         dr_q [F+1][3][2];
  logic [F-1:0]          dq_q [F+1][3][2];
  logic [BW-1:0]         dd_q [F+1][3];
  foad_pkg::region_e     dg_q [F+1][3];
  logic                  dv_q [F+1];

  foad_pkg::region_e     cls_rgn [3];
  logic [BW-1:0]         cls_hi  [3];
  logic [BW-1:0]         cls_lo  [3];
  logic [BW-1:0]         cls_den [3];

  always_comb begin
    for (int s = 0; s < 3; s++) begin
      logic [BW-1:0] b, c, d, x;
      b = bp_q[s][2*BW-1:BW];
      c = bp_q[s][3*BW-1:2*BW];
      d = bp_q[s][4*BW-1:3*BW];
      x = x_q[s];
      cls_hi[s]  = '0;
      cls_lo[s]  = '0;
      cls_den[s] = '0;
      // a has no effect: anything at or below b is fully near
      if (x <= b) begin
        cls_rgn[s] = foad_pkg::RGN_NEAR;
      end else if (x < c) begin
        cls_rgn[s] = foad_pkg::RGN_LOW_RAMP;
        cls_hi[s]  = c - x;
        cls_lo[s]  = x - b;
        cls_den[s] = c - b;
      end else if (x == c) begin
        cls_rgn[s] = foad_pkg::RGN_MED;
      end else if (x < d) begin
        cls_rgn[s] = foad_pkg::RGN_HIGH_RAMP;
        cls_hi[s]  = d - x;
        cls_lo[s]  = x - c;
        cls_den[s] = d - c;
      end else begin
        cls_rgn[s] = foad_pkg::RGN_FAR;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < 3; s++) begin
        dr_q[0][s][0] <= cls_hi[s];
        dr_q[0][s][1] <= cls_lo[s];
        dq_q[0][s][0] <= '0;
        dq_q[0][s][1] <= '0;
        dd_q[0][s]    <= cls_den[s];
        dg_q[0][s]    <= cls_rgn[s];
      end
    end
  end

  // restoring division; in the ramp regions the numerator is below the divisor
  for (genvar k = 0; k < F; k++) begin : g_ramp_div
    logic [BW-1:0] nr [3][2];
    logic          nb [3][2];

    always_comb begin
      for (int s = 0; s < 3; s++) begin
        for (int h = 0; h < 2; h++) begin
          logic [BW:0] t;
          t        = {dr_q[k][s][h], 1'b0};
          nb[s][h] = t >= {1'b0, dd_q[k][s]};
          nr[s][h] = nb[s][h] ? BW'(t - {1'b0, dd_q[k][s]}) : t[BW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int s = 0; s < 3; s++) begin
          for (int h = 0; h < 2; h++) begin
            dr_q[k+1][s][h] <= nr[s][h];
            dq_q[k+1][s][h] <= {dq_q[k][s][h][F-2:0], nb[s][h]};
          end
          dd_q[k+1][s] <= dd_q[k][s];
          dg_q[k+1][s] <= dg_q[k][s];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage m: near / medium / far memberships
  // --------------------------------------------------------------------------
  logic [MW-1:0] mem_q [3][3];
  logic [MW-1:0] mem_d [3][3];
  logic          vm_q;
  logic [MW-1:0] one;

  assign one = {1'b1, {F{1'b0}}};

  always_comb begin
    for (int s = 0; s < 3; s++) begin
      logic [MW-1:0] qh, ql;
      qh = {1'b0, dq_q[F][s][0]};
      ql = {1'b0, dq_q[F][s][1]};
      mem_d[s][0] = '0;
      mem_d[s][1] = '0;
      mem_d[s][2] = '0;
      unique case (dg_q[F][s])
        foad_pkg::RGN_NEAR:      mem_d[s][0] = one;
        foad_pkg::RGN_LOW_RAMP:  begin
          mem_d[s][0] = qh;
          mem_d[s][1] = ql;
        end
        foad_pkg::RGN_MED:       mem_d[s][1] = one;
        foad_pkg::RGN_HIGH_RAMP: begin
          mem_d[s][1] = qh;
          mem_d[s][2] = ql;
        end
        foad_pkg::RGN_FAR:       mem_d[s][2] = one;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mem_q <= mem_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage w: rule strengths, min of three memberships
  // --------------------------------------------------------------------------
  logic [MW-1:0] w_q [27];
  logic [MW-1:0] w_d [27];
  logic          vw_q;

  always_comb begin
    for (int f = 0; f < 3; f++) begin
      for (int l = 0; l < 3; l++) begin
        for (int r = 0; r < 3; r++) begin
          logic [MW-1:0] m;
          m = mem_q[0][f];
          if (mem_q[1][l] < m) m = mem_q[1][l];
          if (mem_q[2][r] < m) m = mem_q[2][r];
          w_d[f*9 + l*3 + r] = m;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_q <= w_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage p: per wheel, per front set, per speed class partial sums
  // --------------------------------------------------------------------------
  logic [S9W-1:0] part_q [2][3][3];
  logic [S9W-1:0] part_d [2][3][3];
  logic           vp_q;

  always_comb begin
    for (int wh = 0; wh < 2; wh++) begin
      for (int f = 0; f < 3; f++) begin
        for (int c = 0; c < 3; c++) begin
          part_d[wh][f][c] = '0;
          for (int i = 0; i < 9; i++) begin
            if (foad_pkg::RULE_SPEED[f*9 + i][wh] == 2'(c)) begin
              part_d[wh][f][c] = part_d[wh][f][c] + S9W'(w_q[f*9 + i]);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      part_q <= part_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage s: total weight per wheel and speed class
  // --------------------------------------------------------------------------
  logic [SUMW-1:0] cls_q [2][3];
  logic            vs_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int wh = 0; wh < 2; wh++) begin
        for (int c = 0; c < 3; c++) begin
          cls_q[wh][c] <= SUMW'(part_q[wh][0][c]) + SUMW'(part_q[wh][1][c])
                        + SUMW'(part_q[wh][2][c]);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage x: weight times speed center; total weight is the same for both wheels
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] prod_q [2][3];
  logic [SUMW-1:0]      den_x_q;
  logic                 vx_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int wh = 0; wh < 2; wh++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[wh][c] <= PW'($signed({1'b0, cls_q[wh][c]})) * PW'(spd_q[c]);
        end
      end
      den_x_q <= cls_q[0][0] + cls_q[0][1] + cls_q[0][2];
    end
  end

  // --------------------------------------------------------------------------
  // stage n and the quotient stages: sign-magnitude division, one bit a stage
  // --------------------------------------------------------------------------
  logic [NW-1:0]   qr_q [QW+1][2];
  logic [QW-1:0]   qq_q [QW+1][2];
  logic            qn_q [QW+1][2];
  logic [SUMW-1:0] qd_q [QW+1];
  logic            qv_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int wh = 0; wh < 2; wh++) begin
        logic signed [NW-1:0] num;
        num = NW'(prod_q[wh][0]) + NW'(prod_q[wh][1]) + NW'(prod_q[wh][2]);
        qn_q[0][wh] <= num[NW-1];
        qr_q[0][wh] <= num[NW-1] ? NW'(-num) : NW'(num);
        qq_q[0][wh] <= '0;
      end
      qd_q[0] <= den_x_q;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_avg_div
    localparam int SH = QW - 1 - k;
    logic [NW-1:0] nr [2];
    logic          nb [2];
    logic [NW-1:0] dsh;

    assign dsh = NW'(qd_q[k]) << SH;

    always_comb begin
      for (int wh = 0; wh < 2; wh++) begin
        nb[wh] = qr_q[k][wh] >= dsh;
        nr[wh] = nb[wh] ? qr_q[k][wh] - dsh : qr_q[k][wh];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        for (int wh = 0; wh < 2; wh++) begin
          qr_q[k+1][wh] <= nr[wh];
          qq_q[k+1][wh] <= {qq_q[k][wh][QW-2:0], nb[wh]};
          qn_q[k+1][wh] <= qn_q[k][wh];
        end
        qd_q[k+1] <= qd_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register: restore sign, zero weight gives zero speed
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] spd_out_d [2];
  logic signed [SW-1:0] spd_out_q [2];

  always_comb begin
    for (int wh = 0; wh < 2; wh++) begin
      if (qd_q[QW] == '0) begin
        spd_out_d[wh] = '0;
      end else if (qn_q[QW][wh]) begin
        spd_out_d[wh] = SW'(-qq_q[QW][wh]);
      end else begin
        spd_out_d[wh] = SW'(qq_q[QW][wh]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      spd_out_q <= spd_out_d;
    end
  end

  assign left_speed_o  = spd_out_q[0];
  assign right_speed_o = spd_out_q[1];
  assign out_valid_o   = out_vld_q;

  // --------------------------------------------------------------------------
  // valid bits travel with the data
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q      <= 1'b0;
      vm_q      <= 1'b0;
      vw_q      <= 1'b0;
      vp_q      <= 1'b0;
      vs_q      <= 1'b0;
      vx_q      <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k <= F; k++) dv_q[k] <= 1'b0;
      for (int k = 0; k <= QW; k++) qv_q[k] <= 1'b0;
    end else if (adv) begin
      va_q    <= in_valid_i;
      dv_q[0] <= va_q;
      for (int k = 0; k < F; k++) dv_q[k+1] <= dv_q[k];
      vm_q    <= dv_q[F];
      vw_q    <= vm_q;
      vp_q    <= vw_q;
      vs_q    <= vp_q;
      vx_q    <= vs_q;
      qv_q[0] <= vx_q;
      for (int k = 0; k < QW; k++) qv_q[k+1] <= qv_q[k];
      out_vld_q <= qv_q[QW];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/foad_chk.sv
// ----------------------------------------------------------------------------
// foad_chk
// port-level checks for the fuzzy drive controller, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "fuzzy_obstacle_avoid_drive_defines.svh"

module foad_chk (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            in_stall_o,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [foad_pkg::SPD_W-1:0]      left_speed_o,
  input wire logic [foad_pkg::SPD_W-1:0]      right_speed_o
);

  logic                         out_held;
  logic [2*foad_pkg::SPD_W-1:0] out_pair;

  assign out_held = out_valid_o && out_stall_i;
  assign out_pair = {left_speed_o, right_speed_o};

  // held output beat stays put
  `FOAD_ASSERT(a_out_hold, out_held |=> out_valid_o && $stable(out_pair), "held beat changed")

  // input side only backs up behind a held output beat
  `FOAD_ASSERT(a_stall_cause, in_stall_o |-> out_held, "input stalled with free output")

  // no output beat in the cycle after reset was seen low
  `FOAD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_o, "output valid after reset")

endmodule

bind fuzzy_obstacle_avoid_drive foad_chk u_foad_chk (.*);

`default_nettype wire
